### rtl/core/chc_pkg.sv
// Shared types and constants for the compass heading CORDIC pipeline.
// No dependencies; compiled first.
`default_nettype none

package chc_pkg;

    localparam int SAMPLE_W  = 16;           // input word width
    localparam int OFFSET_W  = 12;           // offset register width
    localparam int XW        = SAMPLE_W + 3; // CORDIC x/y working width
    localparam int ZW        = 26;           // angle accumulator, degrees Q16
    localparam int AW        = 22;           // angle table entry width
    localparam int FRAC_W    = 16;
    localparam int HEAD_W    = 9;
    localparam int DEG_W     = ZW - FRAC_W;  // signed whole degrees
    localparam int TABLE_LEN = 24;

    typedef logic signed [XW-1:0]       vec_t;
    typedef logic signed [ZW-1:0]       ang_t;
    typedef logic signed [DEG_W-1:0]    deg_t;
    typedef logic        [HEAD_W-1:0]   heading_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OFFSET_W-1:0] offset_t;

    localparam ang_t Z_HALF    = ang_t'(180 * 65536);
    localparam ang_t Z_QUARTER = ang_t'(90 * 65536);
    localparam deg_t DEG_FULL  = deg_t'(360);
    localparam offset_t OFFSET_RESET = offset_t'(20);

    // atan(2^-i) in degrees, Q16, rounded
    localparam logic [AW-1:0] ATAN_Q16 [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // word passed from cell to cell
    typedef struct packed {
        logic upd;   // sample carried a ready bit: compute a new heading
        logic fix;   // angle already exact (vector on an axis)
        vec_t xr;
        vec_t yr;
        ang_t z;
    } cordic_t;

endpackage

`default_nettype wire

### rtl/core/chc_if.sv
// Handshake channel interfaces: sample in, heading out, offset config write.
// Depends on chc_pkg.
`default_nettype none

interface chc_sample_if;
    import chc_pkg::*;
    logic    valid;
    logic    ready;
    sample_t axis_x;
    sample_t axis_w;
    logic    sample_ready;

    modport source (output valid, output axis_x, output axis_w, output sample_ready,
                    input ready);
    modport sink   (input valid, input axis_x, input axis_w, input sample_ready,
                    output ready);
endinterface

interface chc_heading_if;
    import chc_pkg::*;
    logic     valid;
    logic     ready;
    heading_t heading_deg;

    modport source (output valid, output heading_deg, input ready);
    modport sink   (input valid, input heading_deg, output ready);
endinterface

interface chc_cfg_if;
    import chc_pkg::*;
    logic    valid;
    logic    ready;
    offset_t axis_offset;

    modport source (output valid, output axis_offset, input ready);
    modport sink   (input valid, input axis_offset, output ready);
endinterface

`default_nettype wire

### rtl/core/chc_prep.sv
// Entry stage: offset correction, axis special cases, half-plane pre-rotation.
// Depends on chc_pkg.
`default_nettype none

module chc_prep #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_vld,
    output logic                  in_rdy,
    input  wire chc_pkg::sample_t axis_x,
    input  wire chc_pkg::sample_t axis_w,
    input  wire logic             sample_ready,
    input  wire chc_pkg::offset_t offset,
    output logic                  out_vld,
    input  wire logic             out_rdy,
    output chc_pkg::cordic_t      out_word
);
    import chc_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] xs;
    logic signed [SAMPLE_WIDTH-1:0] ws;
    vec_t    xa;
    vec_t    wa;
    vec_t    off;
    vec_t    a;
    vec_t    b;
    cordic_t word_next;
    cordic_t word_reg;
    logic    vld_reg;

    assign xs  = signed'(axis_x[SAMPLE_WIDTH-1:0]);
    assign ws  = signed'(axis_w[SAMPLE_WIDTH-1:0]);
    assign xa  = vec_t'(xs);
    assign wa  = vec_t'(ws);
    assign off = vec_t'(offset);
    assign a   = xa + off;
    assign b   = -(wa + off);

    always_comb
    begin
        word_next.upd = sample_ready;
        word_next.fix = 1'b0;
        word_next.xr  = b;
        word_next.yr  = a;
        word_next.z   = '0;
        if (a == '0)
        begin
            word_next.fix = 1'b1;
            word_next.z   = (b >= 0) ? ang_t'(0) : Z_HALF;
        end
        else if (b == '0)
        begin
            word_next.fix = 1'b1;
            word_next.z   = (a > 0) ? Z_QUARTER : -Z_QUARTER;
        end
        else if (b < 0)
        begin
            word_next.xr = -b;
            word_next.yr = -a;
            word_next.z  = (a >= 0) ? Z_HALF : -Z_HALF;
        end
    end

    assign in_rdy = !vld_reg || out_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            word_reg <= word_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;

endmodule

`default_nettype wire

### rtl/core/chc_cell.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on chc_pkg (word type, angle table).
`default_nettype none

module chc_cell #(
    parameter int STEP = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_vld,
    output logic                  in_rdy,
    input  wire chc_pkg::cordic_t in_word,
    output logic                  out_vld,
    input  wire logic             out_rdy,
    output chc_pkg::cordic_t      out_word
);
    import chc_pkg::*;

    localparam ang_t ANGLE = ang_t'(ATAN_Q16[STEP]);

    vec_t    sx;
    vec_t    sy;
    cordic_t word_next;
    cordic_t word_reg;
    logic    vld_reg;

    assign sx = in_word.xr >>> STEP;
    assign sy = in_word.yr >>> STEP;

    always_comb
    begin
        word_next = in_word;
        if (in_word.upd && !in_word.fix)
        begin
            if (in_word.yr >= 0)
            begin
                word_next.xr = in_word.xr + sy;
                word_next.yr = in_word.yr - sx;
                word_next.z  = in_word.z + ANGLE;
            end
            else
            begin
                word_next.xr = in_word.xr - sy;
                word_next.yr = in_word.yr + sx;
                word_next.z  = in_word.z - ANGLE;
            end
        end
    end

    assign in_rdy = !vld_reg || out_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld && in_rdy)
        begin
            word_reg <= word_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;

endmodule

`default_nettype wire

### rtl/core/chc_finish.sv
// Output stage: angle to whole-degree heading, wrap to 0..359, hold last heading.
// Depends on chc_pkg.
`default_nettype none

module chc_finish (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_vld,
    output logic                  in_rdy,
    input  wire chc_pkg::cordic_t in_word,
    output logic                  out_vld,
    input  wire logic             out_rdy,
    output chc_pkg::heading_t     heading_deg
);
    import chc_pkg::*;

    ang_t     total;
    deg_t     deg;
    deg_t     deg_wrap;
    heading_t head_new;
    heading_t last_reg;
    heading_t head_reg;
    logic     vld_reg;
    logic     take;

    assign total = in_word.z + Z_HALF;
    assign deg   = total[ZW-1:FRAC_W];

    always_comb
    begin
        deg_wrap = deg;
        if (deg < 0)
        begin
            deg_wrap = deg + DEG_FULL;
        end
        else if (deg >= DEG_FULL)
        begin
            deg_wrap = deg - DEG_FULL;
        end
    end

    assign head_new = deg_wrap[HEAD_W-1:0];
    assign in_rdy   = !vld_reg || out_rdy;
    assign take     = in_vld && in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            if (in_rdy)
            begin
                vld_reg <= in_vld;
            end
            if (take && in_word.upd)
            begin
                last_reg <= head_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            head_reg <= in_word.upd ? head_new : last_reg;
        end
    end

    assign out_vld     = vld_reg;
    assign heading_deg = head_reg;

endmodule

`default_nettype wire

### rtl/core/compass_heading_from_field.sv
// Compass heading from one magnetometer sample per word, unrolled CORDIC.
// Depends on chc_pkg, chc_if, chc_prep, chc_cell, chc_finish.
//
// Each sample word gives one heading word, 0..359 degrees, in input order.
// The sample enters an entry stage, a row of min(CORDIC_STEPS, 24) rotation
// cells and an output stage, each registered; a new sample is taken every
// cycle unless the output stalls. Each stage has its own valid bit and
// takes a word when it is empty or its neighbor is taking its word, so bubbles
// close up under output stall. A sample without its ready bit returns the last
// computed heading (0 after reset). The offset write channel is always ready;
// write it only while the pipeline is empty.
`default_nettype none

module compass_heading_from_field #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    chc_sample_if.sink  sample,
    chc_heading_if.source heading,
    chc_cfg_if.sink     cfg
);
    import chc_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    offset_t offset_reg;
    cordic_t word [NSTEP+1];
    logic    vld  [NSTEP+1];
    logic    rdy  [NSTEP+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg.valid)
        begin
            offset_reg <= cfg.axis_offset;
        end
    end

    chc_prep #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (sample.valid),
        .in_rdy       (sample.ready),
        .axis_x       (sample.axis_x),
        .axis_w       (sample.axis_w),
        .sample_ready (sample.sample_ready),
        .offset       (offset_reg),
        .out_vld      (vld[0]),
        .out_rdy      (rdy[0]),
        .out_word     (word[0])
    );

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cell
        chc_cell #(
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld[i]),
            .in_rdy   (rdy[i]),
            .in_word  (word[i]),
            .out_vld  (vld[i+1]),
            .out_rdy  (rdy[i+1]),
            .out_word (word[i+1])
        );
    end

    chc_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (vld[NSTEP]),
        .in_rdy      (rdy[NSTEP]),
        .in_word     (word[NSTEP]),
        .out_vld     (heading.valid),
        .out_rdy     (heading.ready),
        .heading_deg (heading.heading_deg)
    );

endmodule

`default_nettype wire
